@@ rtl/dnd_pkg.sv @@
// ----------------------------------------------------------------------------
// dnd_pkg
// Shared constants, command codes and status types for the DNS name
// decompressor: message store geometry, label tags and walk commands.
// ----------------------------------------------------------------------------
package dnd_pkg;

    // Message store geometry
    localparam int PKT_BYTES = 512;
    localparam int PKT_AW    = $clog2(PKT_BYTES);
    localparam int PLEN_W    = $clog2(PKT_BYTES + 1);

    // Walk position: 14-bit offsets plus one step past the end
    localparam int POS_W     = 15;

    // Configuration port
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_NAME_LEN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOPS     = 2'd1;

    localparam logic [8:0] MAX_NAME_LEN_RST = 9'd256;
    localparam logic [7:0] MAX_HOPS_RST     = 8'd64;

    // Label byte constants
    localparam logic [1:0] TAG_PTR    = 2'b11;
    localparam logic [1:0] TAG_LABEL  = 2'b00;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;

    // Result status codes
    typedef logic [1:0] t_status;
    localparam t_status ST_OK   = 2'd0;
    localparam t_status ST_LONG = 2'd1;
    localparam t_status ST_RSV  = 2'd2;
    localparam t_status ST_HOP  = 2'd3;

    // Datapath commands
    typedef logic [3:0] t_op;
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_LOAD     = 4'd1;
    localparam t_op OP_START    = 4'd2;
    localparam t_op OP_RD       = 4'd3;
    localparam t_op OP_RD1      = 4'd4;
    localparam t_op OP_PTR_HEAD = 4'd5;
    localparam t_op OP_PTR_ZERO = 4'd6;
    localparam t_op OP_PTR_SET  = 4'd7;
    localparam t_op OP_END_OK   = 4'd8;
    localparam t_op OP_ERR_HOP  = 4'd9;
    localparam t_op OP_ERR_RSV  = 4'd10;
    localparam t_op OP_ERR_LONG = 4'd11;
    localparam t_op OP_LABEL    = 4'd12;
    localparam t_op OP_DOT      = 4'd13;
    localparam t_op OP_TEXT     = 4'd14;
    localparam t_op OP_FINISH   = 4'd15;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic pos_in;      // walk position inside the message
        logic pos1_in;     // position plus one inside the message
        logic hd_zero;     // header byte is the root label
        logic hd_ptr;      // header byte is a compression pointer
        logic hd_rsv;      // header byte has a reserved type
        logic hop_over;    // pointer budget used up
        logic too_long;    // label would overflow the name buffer
        logic cnt_zero;    // label text exhausted
        logic len_nz;      // name text already holds a label
        logic can_append;  // chunk has room or can spill now
        logic out_free;    // output register can take a chunk
    } t_stat;

endpackage

@@ rtl/dns_name_decompressor.sv @@
// A load request leaves the sequencer idle, so a new request can be taken after it.
// A decode reads each label header, pointer and text byte from the message store,
// adds dots between labels, and closes; the store's single read port sets the pace.
// Chunks leave through an output register; the walk holds while it is full.
// Reset (synchronous, active low) empties the message, arms the next load as a
// restart, and sets max_name_len to 256 and max_pointer_hops to 64.
// ----------------------------------------------------------------------------
// dns_name_decompressor
// Loads a DNS message byte by byte and decodes compressed names from it into
// dotted text, emitted in 8-byte chunks with length, next offset and status.
// ----------------------------------------------------------------------------
module dns_name_decompressor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_load_last,
    input  logic [13:0]                   i_start_offset,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [63:0]                   o_name_chunk,
    output logic [3:0]                    o_chunk_bytes,
    output logic                          o_chunk_last,
    output logic [7:0]                    o_name_length,
    output logic [14:0]                   o_next_offset,
    output logic [1:0]                    o_status,
    input  logic                          i_cfg_we,
    input  logic [dnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dnd_pkg::CFG_W-1:0]     i_cfg_data
);

    dnd_pkg::t_op   w_op;
    dnd_pkg::t_stat w_stat;

    // Sequencer
    dnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_req_type),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_op       (w_op)
    );

    // Store, walk registers and output stage
    dnd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (w_op),
        .i_data_byte    (i_data_byte),
        .i_load_last    (i_load_last),
        .i_start_offset (i_start_offset),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_out_ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_name_chunk   (o_name_chunk),
        .o_chunk_bytes  (o_chunk_bytes),
        .o_chunk_last   (o_chunk_last),
        .o_name_length  (o_name_length),
        .o_next_offset  (o_next_offset),
        .o_status       (o_status)
    );

endmodule

@@ rtl/dnd_ctrl.sv @@
// ----------------------------------------------------------------------------
// dnd_ctrl
// Walk sequencer: accepts requests, steps through label headers, pointers
// and label text, and issues one datapath command per cycle, except while it waits in idle or for output room.
// ----------------------------------------------------------------------------
module dnd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_req_type,
    input  dnd_pkg::t_stat i_stat,
    output logic          o_in_ready,
    output dnd_pkg::t_op  o_op
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_HRD  = 4'd1;
    localparam logic [3:0] S_HEAD = 4'd2;
    localparam logic [3:0] S_P1   = 4'd3;
    localparam logic [3:0] S_PTR  = 4'd4;
    localparam logic [3:0] S_DOT  = 4'd5;
    localparam logic [3:0] S_TRD  = 4'd6;
    localparam logic [3:0] S_TXT  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and command
    always_comb begin
        n_state = r_state;
        o_op    = dnd_pkg::OP_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_req_type) begin
                        o_op    = dnd_pkg::OP_START;
                        n_state = S_HRD;
                    end else begin
                        o_op = dnd_pkg::OP_LOAD;
                    end
                end
            end
            S_HRD: begin
                if (!i_stat.pos_in) begin
                    o_op    = dnd_pkg::OP_END_OK;
                    n_state = S_FIN;
                end else begin
                    o_op    = dnd_pkg::OP_RD;
                    n_state = S_HEAD;
                end
            end
            S_HEAD: begin
                if (i_stat.hd_zero) begin
                    o_op    = dnd_pkg::OP_END_OK;
                    n_state = S_FIN;
                end else if (i_stat.hd_ptr) begin
                    if (i_stat.hop_over) begin
                        o_op    = dnd_pkg::OP_ERR_HOP;
                        n_state = S_FIN;
                    end else begin
                        o_op    = dnd_pkg::OP_PTR_HEAD;
                        n_state = S_P1;
                    end
                end else if (i_stat.hd_rsv) begin
                    o_op    = dnd_pkg::OP_ERR_RSV;
                    n_state = S_FIN;
                end else if (i_stat.too_long) begin
                    o_op    = dnd_pkg::OP_ERR_LONG;
                    n_state = S_FIN;
                end else begin
                    o_op    = dnd_pkg::OP_LABEL;
                    n_state = i_stat.len_nz ? S_DOT : S_TRD;
                end
            end
            S_P1: begin
                if (i_stat.pos1_in) begin
                    o_op    = dnd_pkg::OP_RD1;
                    n_state = S_PTR;
                end else begin
                    o_op    = dnd_pkg::OP_PTR_ZERO;
                    n_state = S_HRD;
                end
            end
            S_PTR: begin
                o_op    = dnd_pkg::OP_PTR_SET;
                n_state = S_HRD;
            end
            S_DOT: begin
                if (i_stat.can_append) begin
                    o_op    = dnd_pkg::OP_DOT;
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                // End of label text falls straight into the next header read
                if (!i_stat.pos_in) begin
                    o_op    = dnd_pkg::OP_END_OK;
                    n_state = S_FIN;
                end else if (i_stat.cnt_zero) begin
                    o_op    = dnd_pkg::OP_RD;
                    n_state = S_HEAD;
                end else begin
                    o_op    = dnd_pkg::OP_RD;
                    n_state = S_TXT;
                end
            end
            S_TXT: begin
                if (i_stat.can_append) begin
                    o_op    = dnd_pkg::OP_TEXT;
                    n_state = S_TRD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_op    = dnd_pkg::OP_FINISH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/dnd_datapath.sv @@
// ----------------------------------------------------------------------------
// dnd_datapath
// Message store, configuration registers, walk position and counters,
// chunk assembly and the output register.
// ----------------------------------------------------------------------------
module dnd_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dnd_pkg::t_op                  i_op,
    input  logic [7:0]                    i_data_byte,
    input  logic                          i_load_last,
    input  logic [13:0]                   i_start_offset,
    input  logic                          i_cfg_we,
    input  logic [dnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [dnd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_out_ready,
    output dnd_pkg::t_stat                o_stat,
    output logic                          o_out_valid,
    output logic [63:0]                   o_name_chunk,
    output logic [3:0]                    o_chunk_bytes,
    output logic                          o_chunk_last,
    output logic [7:0]                    o_name_length,
    output logic [14:0]                   o_next_offset,
    output logic [1:0]                    o_status
);

    logic [7:0]                  r_mem [dnd_pkg::PKT_BYTES];
    logic [7:0]                  r_rdata;
    logic [dnd_pkg::PLEN_W-1:0]  r_plen;
    logic                        r_restart;
    logic [8:0]                  r_max_len;
    logic [7:0]                  r_max_hops;

    logic [dnd_pkg::POS_W-1:0]   r_pos;
    logic [7:0]                  r_len;
    logic [7:0]                  r_hops;
    logic                        r_jumped;
    logic [dnd_pkg::POS_W-1:0]   r_nxt;
    dnd_pkg::t_status            r_stat_code;
    logic [5:0]                  r_hi;
    logic [5:0]                  r_cnt;
    logic [63:0]                 r_chunk;
    logic [3:0]                  r_ccnt;

    logic                        r_out_valid;
    logic [63:0]                 r_o_chunk;
    logic [3:0]                  r_o_bytes;
    logic                        r_o_last;
    logic [7:0]                  r_o_len;
    logic [14:0]                 r_o_nxt;
    dnd_pkg::t_status            r_o_status;

    logic [dnd_pkg::PLEN_W-1:0]  w_widx;
    logic                        w_wr_ok;
    logic [dnd_pkg::POS_W:0]     w_pos_p1;
    logic [dnd_pkg::POS_W-1:0]   w_pos_inc;
    logic [dnd_pkg::POS_W-1:0]   w_pos_inc2;
    logic [8:0]                  w_lim;
    logic [9:0]                  w_need;
    logic                        w_append;
    logic [7:0]                  w_abyte;
    logic                        w_spill;
    logic                        w_out_free;
    logic                        w_out_load;
    logic                        w_rd_en;
    logic [dnd_pkg::PKT_AW-1:0]  w_rd_addr;

    // Store index for a load; a restart begins at offset zero
    assign w_widx  = r_restart ? '0 : r_plen;
    assign w_wr_ok = (w_widx < dnd_pkg::PLEN_W'(dnd_pkg::PKT_BYTES));

    assign w_pos_p1   = {1'b0, r_pos} + 1'b1;
    assign w_pos_inc  = r_pos + dnd_pkg::POS_W'(1);
    assign w_pos_inc2 = r_pos + dnd_pkg::POS_W'(2);

    // Name buffer limit and label size test
    assign w_lim  = (r_max_len > 9'd256) ? 9'd256 : r_max_len;
    assign w_need = {2'b00, r_len} + {2'b00, r_rdata} + 10'd1;

    // Chunk append and spill of a full chunk
    assign w_append   = (i_op == dnd_pkg::OP_DOT) || (i_op == dnd_pkg::OP_TEXT);
    assign w_abyte    = (i_op == dnd_pkg::OP_DOT) ? dnd_pkg::DOT_CHAR : r_rdata;
    assign w_spill    = w_append && (r_ccnt == 4'd8);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_load = w_spill || (i_op == dnd_pkg::OP_FINISH);

    assign w_rd_en   = (i_op == dnd_pkg::OP_RD) || (i_op == dnd_pkg::OP_RD1);
    assign w_rd_addr = (i_op == dnd_pkg::OP_RD1) ? w_pos_p1[dnd_pkg::PKT_AW-1:0]
                                                 : r_pos[dnd_pkg::PKT_AW-1:0];

    // Flags to the controller
    assign o_stat.pos_in     = (r_pos < dnd_pkg::POS_W'(r_plen));
    assign o_stat.pos1_in    = (w_pos_p1 < (dnd_pkg::POS_W + 1)'(r_plen));
    assign o_stat.hd_zero    = (r_rdata == 8'd0);
    assign o_stat.hd_ptr     = (r_rdata[7:6] == dnd_pkg::TAG_PTR);
    assign o_stat.hd_rsv     = (r_rdata[7:6] != dnd_pkg::TAG_PTR)
                            && (r_rdata[7:6] != dnd_pkg::TAG_LABEL);
    assign o_stat.hop_over   = (r_hops >= r_max_hops);
    assign o_stat.too_long   = (w_need >= {1'b0, w_lim});
    assign o_stat.cnt_zero   = (r_cnt == 6'd0);
    assign o_stat.len_nz     = (r_len != 8'd0);
    assign o_stat.can_append = (r_ccnt != 4'd8) || w_out_free;
    assign o_stat.out_free   = w_out_free;

    // Control state: message length, restart flag, config, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen      <= '0;
            r_restart   <= 1'b1;
            r_max_len   <= dnd_pkg::MAX_NAME_LEN_RST;
            r_max_hops  <= dnd_pkg::MAX_HOPS_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    dnd_pkg::CFG_MAX_NAME_LEN: r_max_len  <= i_cfg_data;
                    dnd_pkg::CFG_MAX_HOPS:     r_max_hops <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_op == dnd_pkg::OP_LOAD) begin
                if (w_wr_ok) begin
                    r_plen <= w_widx + 1'b1;
                end else begin
                    r_plen <= w_widx;
                end
                r_restart <= i_load_last;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Message store write port
    always_ff @(posedge i_clk) begin
        if ((i_op == dnd_pkg::OP_LOAD) && w_wr_ok) begin
            r_mem[w_widx[dnd_pkg::PKT_AW-1:0]] <= i_data_byte;
        end
    end

    // Message store read port, registered
    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // Walk registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            dnd_pkg::OP_START: begin
                r_pos       <= {1'b0, i_start_offset};
                r_len       <= 8'd0;
                r_hops      <= 8'd0;
                r_jumped    <= 1'b0;
                r_nxt       <= '0;
                r_stat_code <= dnd_pkg::ST_OK;
                r_cnt       <= 6'd0;
            end
            dnd_pkg::OP_PTR_HEAD: begin
                if (!r_jumped) begin
                    r_nxt    <= w_pos_inc2;
                    r_jumped <= 1'b1;
                end
                r_hops <= r_hops + 8'd1;
                r_hi   <= r_rdata[5:0];
            end
            dnd_pkg::OP_PTR_ZERO: begin
                r_pos <= {1'b0, r_hi, 8'h00};
            end
            dnd_pkg::OP_PTR_SET: begin
                r_pos <= {1'b0, r_hi, r_rdata};
            end
            dnd_pkg::OP_END_OK: begin
                if (!r_jumped) begin
                    r_nxt <= w_pos_inc;
                end
                r_stat_code <= dnd_pkg::ST_OK;
            end
            dnd_pkg::OP_ERR_HOP: begin
                if (!r_jumped) begin
                    r_nxt <= w_pos_inc2;
                end
                r_stat_code <= dnd_pkg::ST_HOP;
            end
            dnd_pkg::OP_ERR_RSV: begin
                if (!r_jumped) begin
                    r_nxt <= w_pos_inc;
                end
                r_stat_code <= dnd_pkg::ST_RSV;
            end
            dnd_pkg::OP_ERR_LONG: begin
                if (!r_jumped) begin
                    r_nxt <= w_pos_inc;
                end
                r_stat_code <= dnd_pkg::ST_LONG;
            end
            dnd_pkg::OP_LABEL: begin
                r_pos <= w_pos_inc;
                r_cnt <= r_rdata[5:0];
            end
            dnd_pkg::OP_DOT: begin
                r_len <= r_len + 8'd1;
            end
            dnd_pkg::OP_TEXT: begin
                r_len <= r_len + 8'd1;
                r_pos <= w_pos_inc;
                r_cnt <= r_cnt - 6'd1;
            end
            default: ;
        endcase
    end

    // Chunk assembly: clear on start, spill a full chunk before appending
    always_ff @(posedge i_clk) begin
        if (i_op == dnd_pkg::OP_START) begin
            r_chunk <= 64'd0;
            r_ccnt  <= 4'd0;
        end else if (w_append) begin
            if (w_spill) begin
                r_chunk <= {56'd0, w_abyte};
                r_ccnt  <= 4'd1;
            end else begin
                r_chunk[{r_ccnt[2:0], 3'b000} +: 8] <= w_abyte;
                r_ccnt <= r_ccnt + 4'd1;
            end
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_op == dnd_pkg::OP_FINISH) begin
            r_o_chunk  <= r_chunk;
            r_o_bytes  <= r_ccnt;
            r_o_last   <= 1'b1;
            r_o_len    <= r_len;
            r_o_nxt    <= r_nxt;
            r_o_status <= r_stat_code;
        end else if (w_spill) begin
            r_o_chunk  <= r_chunk;
            r_o_bytes  <= 4'd8;
            r_o_last   <= 1'b0;
            r_o_len    <= 8'd0;
            r_o_nxt    <= 15'd0;
            r_o_status <= dnd_pkg::ST_OK;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_name_chunk  = r_o_chunk;
    assign o_chunk_bytes = r_o_bytes;
    assign o_chunk_last  = r_o_last;
    assign o_name_length = r_o_len;
    assign o_next_offset = r_o_nxt;
    assign o_status      = r_o_status;

endmodule

@@ rtl/dnd_checker.sv @@
// ----------------------------------------------------------------------------
// dnd_checker
// Port-level checks on the decompressor: output hold, chunk framing, request
// blocking during a decode, and reset state.
// ----------------------------------------------------------------------------
module dnd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          o_in_ready,
    input logic                          i_req_type,
    input logic [7:0]                    i_data_byte,
    input logic                          i_load_last,
    input logic [13:0]                   i_start_offset,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [63:0]                   o_name_chunk,
    input logic [3:0]                    o_chunk_bytes,
    input logic                          o_chunk_last,
    input logic [7:0]                    o_name_length,
    input logic [14:0]                   o_next_offset,
    input logic [1:0]                    o_status,
    input logic                          i_cfg_we,
    input logic [dnd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [dnd_pkg::CFG_W-1:0]     i_cfg_data
);

    // Hold a stalled chunk
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_name_chunk)
            && $stable(o_chunk_bytes) && $stable(o_chunk_last))
        else $error("stalled chunk changed");

    // Non-final chunks are full and carry no summary
    a_mid_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_chunk_last |-> o_chunk_bytes == 4'd8
            && o_name_length == 8'd0 && o_next_offset == 15'd0
            && o_status == dnd_pkg::ST_OK)
        else $error("non-final chunk malformed");

    // Final chunk is empty only for an empty name, and never overfull
    a_last_chunk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_chunk_last |-> o_chunk_bytes <= 4'd8
            && (o_chunk_bytes != 4'd0 || o_name_length == 8'd0))
        else $error("final chunk byte count inconsistent");

    // Block new requests once a decode starts
    a_decode_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_req_type |=> !o_in_ready)
        else $error("request taken during decode walk");

    // Drop output valid and raise input ready out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind dns_name_decompressor dnd_checker u_dnd_checker (.*);
